// ----- rtl/epq_pkg.sv -----
// Package for the expiry priority queue: transaction types, mode and status codes,
// the per-cell operation codes and the default capacity.
// No dependencies.
`default_nettype none

package epq_pkg;

  localparam int unsigned CapacityDef = 16;

  localparam int unsigned IdW    = 16;
  localparam int unsigned KeyW   = 20;
  localparam int unsigned CountW = 5;

  typedef enum logic [2:0] {
    MODE_PRIO   = 3'd0,
    MODE_TAIL   = 3'd1,
    MODE_POP    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_QUERY  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEARCH_KEY  = 2'd0,
    SEARCH_FREE = 2'd1,
    SEARCH_ID   = 2'd2,
    SEARCH_HEAD = 2'd3
  } search_e;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_LEFT  = 2'd2,
    OP_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [2:0]      mode;
    logic [IdW-1:0]  item_id;
    logic [KeyW-1:0] expiry_minutes;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IdW-1:0]    out_id;
    logic [KeyW-1:0]   out_expiry;
    logic              present;
    logic [CountW-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } entry_t;

  typedef struct packed {
    search_e search;
    entry_t  ent;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/expiry_priority_queue_unit.sv -----
// Top level of the expiry priority queue: a chain of epq_cell slots, the
// occupancy count and the result register. Depends on epq_pkg and epq_cell.
//
// The queue takes one transaction per clock and returns its result in the next
// cycle from a result register; it keeps taking one transaction per clock as
// long as the result side is not stalled. Every slot compares its own entry
// with the request in the same cycle, a parallel prefix over the per-slot
// flags finds the first hit, and each slot then holds, loads the new entry or
// takes its left or right neighbor, so inserts, pops and removals all finish
// in that same cycle. Slots at or above the count hold no valid entry; after
// reset the queue is empty and ready at once.
`default_nettype none

module expiry_priority_queue_unit import epq_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count_q, count_d;
  logic                out_valid_q;
  out_t                out_q, out_d;
  logic                accept;
  logic                full;
  logic                found;
  logic                is_insert, is_remove;
  cell_cmd_t           cmd;
  logic [CAPACITY-1:0] valid, cand, lt, le, at;
  entry_t              ent [CAPACITY];
  cell_op_e            op  [CAPACITY];
  entry_t              removed;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(CAPACITY));
  assign found      = |cand;

  always_comb begin
    cmd.ent.id  = in_data_i.item_id;
    cmd.ent.key = in_data_i.expiry_minutes;
    is_insert   = 1'b0;
    is_remove   = 1'b0;
    unique case (in_data_i.mode)
      MODE_PRIO: begin
        cmd.search = SEARCH_KEY;
        is_insert  = 1'b1;
      end
      MODE_TAIL: begin
        cmd.search = SEARCH_FREE;
        is_insert  = 1'b1;
      end
      MODE_POP: begin
        cmd.search = SEARCH_HEAD;
        is_remove  = 1'b1;
      end
      MODE_REMOVE: begin
        cmd.search = SEARCH_ID;
        is_remove  = 1'b1;
      end
      MODE_QUERY: cmd.search = SEARCH_ID;
      default:    cmd.search = SEARCH_FREE;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_first
      assign lt[i] = 1'b0;
    end else begin : g_rest
      assign lt[i] = |cand[i-1:0];
    end
    assign le[i] = lt[i] | cand[i];
    assign at[i] = cand[i] & ~lt[i];

    always_comb begin
      op[i] = OP_HOLD;
      if (accept && is_insert && !full) begin
        if (at[i]) begin
          op[i] = OP_LOAD;
        end else if (lt[i]) begin
          op[i] = OP_LEFT;
        end
      end else if (accept && is_remove && found && le[i]) begin
        op[i] = OP_RIGHT;
      end
    end

    epq_cell #(
      .IsHead (i == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .valid_i (valid[i]),
      .cmd_i   (cmd),
      .op_i    (op[i]),
      .left_i  ((i == 0) ? cmd.ent : ent[(i == 0) ? 0 : i - 1]),
      .right_i ((i == CAPACITY - 1) ? ent[i] : ent[(i == CAPACITY - 1) ? i : i + 1]),
      .entry_o (ent[i]),
      .cand_o  (cand[i])
    );
  end

  always_comb begin
    removed = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (at[i]) begin
        removed = entry_t'(removed | ent[i]);
      end
    end
  end

  always_comb begin
    count_d         = count_q;
    out_d.status    = STATUS_DONE;
    out_d.out_id    = '0;
    out_d.out_expiry = '0;
    out_d.present   = 1'b0;
    if (is_insert) begin
      if (full) begin
        out_d.status = STATUS_FULL;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else if (is_remove) begin
      if (found) begin
        count_d          = count_q - CW'(1);
        out_d.out_id     = removed.id;
        out_d.out_expiry = removed.key;
        out_d.present    = (in_data_i.mode == MODE_REMOVE);
      end else begin
        out_d.status = STATUS_MISS;
      end
    end else if (in_data_i.mode == MODE_QUERY) begin
      if (found) begin
        out_d.present = 1'b1;
      end else begin
        out_d.status = STATUS_MISS;
      end
    end
    out_d.entry_count = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/epq_cell.sv -----
// One queue slot: holds an entry, flags whether it is the search target,
// and loads, holds or takes its neighbor's entry. Depends on epq_pkg.
`default_nettype none

module epq_cell import epq_pkg::*; #(
  parameter bit IsHead = 1'b0
) (
  input  wire logic      clk_i,
  input  wire logic      valid_i,
  input  wire cell_cmd_t cmd_i,
  input  wire cell_op_e  op_i,
  input  wire entry_t    left_i,
  input  wire entry_t    right_i,
  output entry_t         entry_o,
  output logic           cand_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    unique case (cmd_i.search)
      SEARCH_KEY: begin
        if (IsHead) begin
          cand_o = !valid_i || (entry_q.key > cmd_i.ent.key);
        end else begin
          cand_o = !valid_i || (entry_q.key >= cmd_i.ent.key);
        end
      end
      SEARCH_FREE: cand_o = !valid_i;
      SEARCH_ID:   cand_o = valid_i && (entry_q.id == cmd_i.ent.id);
      SEARCH_HEAD: cand_o = IsHead && valid_i;
      default:     cand_o = 1'b0;
    endcase
  end

  always_comb begin
    unique case (op_i)
      OP_HOLD:  entry_d = entry_q;
      OP_LOAD:  entry_d = cmd_i.ent;
      OP_LEFT:  entry_d = left_i;
      OP_RIGHT: entry_d = right_i;
      default:  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- verif/epq_result_checker.sv -----
// Result checker for expiry_priority_queue_unit: watches both channels, keeps a
// shadow copy of the queue and compares every result field by field.
// Depends on epq_pkg.
module epq_result_checker import epq_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t shadow_q [CAPACITY];
  int     shadow_len = 0;
  out_t   expected_results [$];
  int     mismatch_count = 0;
  int     result_count = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int find_id(input logic [IdW-1:0] id);
    for (int i = 0; i < shadow_len; i++) begin
      if (shadow_q[i].id == id) begin
        return i;
      end
    end
    return shadow_len;
  endfunction

  function automatic entry_t take_slot(input int pos);
    entry_t gone;
    gone = shadow_q[pos];
    for (int i = pos; i + 1 < shadow_len; i++) begin
      shadow_q[i] = shadow_q[i + 1];
    end
    shadow_len--;
    return gone;
  endfunction

  function automatic out_t apply_request(input in_t req);
    out_t   res;
    entry_t gone;
    int     pos;
    res = '0;
    case (req.mode)
      MODE_PRIO, MODE_TAIL: begin
        if (shadow_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          if (req.mode == MODE_TAIL) begin
            pos = shadow_len;
          end else if (shadow_len == 0 || shadow_q[0].key > req.expiry_minutes) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < shadow_len && shadow_q[pos].key < req.expiry_minutes) begin
              pos++;
            end
          end
          for (int i = shadow_len; i > pos; i--) begin
            shadow_q[i] = shadow_q[i - 1];
          end
          shadow_q[pos].id  = req.item_id;
          shadow_q[pos].key = req.expiry_minutes;
          shadow_len++;
        end
      end
      MODE_POP: begin
        if (shadow_len == 0) begin
          res.status = STATUS_MISS;
        end else begin
          gone           = take_slot(0);
          res.out_id     = gone.id;
          res.out_expiry = gone.key;
        end
      end
      MODE_REMOVE: begin
        pos = find_id(req.item_id);
        if (pos >= shadow_len) begin
          res.status = STATUS_MISS;
        end else begin
          gone           = take_slot(pos);
          res.out_id     = gone.id;
          res.out_expiry = gone.key;
          res.present    = 1'b1;
        end
      end
      MODE_QUERY: begin
        if (find_id(req.item_id) < shadow_len) begin
          res.present = 1'b1;
        end else begin
          res.status = STATUS_MISS;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = CountW'(shadow_len);
    return res;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_request(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_i, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status != want.status) begin
            report_mismatch("status", out_data_i.status, want.status);
          end
          if (out_data_i.out_id != want.out_id) begin
            report_mismatch("out_id", out_data_i.out_id, want.out_id);
          end
          if (out_data_i.out_expiry != want.out_expiry) begin
            report_mismatch("out_expiry", out_data_i.out_expiry, want.out_expiry);
          end
          if (out_data_i.present != want.present) begin
            report_mismatch("present", out_data_i.present, want.present);
          end
          if (out_data_i.entry_count != want.entry_count) begin
            report_mismatch("entry_count", out_data_i.entry_count, want.entry_count);
          end
        end
      end
    end
    pending_o    <= expected_results.size();
    mismatches_o <= mismatch_count;
    results_o    <= result_count;
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top for expiry_priority_queue_unit: clock, reset, directed and random
// transactions under changing gap and stall profiles, and the final verdict.
// Depends on epq_pkg, the queue RTL and epq_result_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import epq_pkg::*;

  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam int RandomItems = 630;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 4;
  localparam int IdPoolSize  = 8;
  localparam logic [2:0][6:0] SendGapPct   = {7'd0, 7'd64, 7'd31};
  localparam logic [2:0][6:0] RecvStallPct = {7'd0, 7'd31, 7'd64};
  localparam logic [2:0][6:0] FillPct      = {7'd15, 7'd50, 7'd85};

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int mismatches;
  int pending;
  int results;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int          cycle_count = 0;
  int          sent_count = 0;
  int          spare_count = 0;
  logic [IdW-1:0] id_pool [IdPoolSize];

  expiry_priority_queue_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  epq_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_t make_request(input logic [2:0] mode, input logic [IdW-1:0] id,
                                       input logic [KeyW-1:0] key);
    in_t req;
    req.mode           = mode;
    req.item_id        = id;
    req.expiry_minutes = key;
    return req;
  endfunction

  task automatic send_request(input in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent_count++;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      in_data  <= $bits(in_t)'({$urandom, $urandom});
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  initial begin
    in_t             req;
    logic [2:0]      mode;
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
    int unsigned     fill_pct;
    int unsigned     roll;

    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < IdPoolSize; i++) begin
      id_pool[i] = IdW'($urandom);
    end
    fill_pct  = FillPct[0];
    gap_pct   = SendGapPct[0];
    stall_pct = RecvStallPct[0];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_request(make_request(MODE_POP, 16'h0000, 20'h00000));
    send_request(make_request(MODE_REMOVE, 16'hffff, 20'hfffff));
    send_request(make_request(MODE_QUERY, 16'h8001, 20'h00000));
    send_request(make_request(MODE_SPARE_FIRST, 16'hffff, 20'hfffff));
    send_request(make_request(MODE_SPARE_LAST, 16'h5a5a, 20'h12345));
    spare_count += 2;
    send_request(make_request(MODE_PRIO, 16'h0000, 20'h80000));
    send_request(make_request(MODE_PRIO, 16'hffff, 20'h00000));
    send_request(make_request(MODE_PRIO, 16'h0042, 20'hfffff));
    send_request(make_request(MODE_TAIL, 16'h1234, 20'h00005));
    send_request(make_request(MODE_PRIO, 16'h0007, 20'h00005));
    send_request(make_request(MODE_PRIO, 16'h0099, 20'hfffff));
    send_request(make_request(MODE_QUERY, 16'hffff, 20'h00000));
    send_request(make_request(MODE_REMOVE, 16'h1234, 20'h00000));
    for (int i = 0; i < CapacityDef - 5; i++) begin
      send_request(make_request(MODE_TAIL, id_pool[i % IdPoolSize], KeyW'($urandom)));
    end
    send_request(make_request(MODE_PRIO, 16'h0101, 20'h00000));
    send_request(make_request(MODE_TAIL, 16'h0202, 20'hfffff));

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct   = SendGapPct[ph];
      stall_pct = RecvStallPct[ph];
      for (int n = 0; n < RandomItems / 3; n++) begin
        if (n % 30 == 0) begin
          fill_pct = FillPct[$urandom_range(2)];
        end
        if ($urandom_range(99) < 4) begin
          mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
          send_request(make_request(mode, IdW'($urandom), KeyW'($urandom)));
          spare_count++;
        end
        if ($urandom_range(99) < 3) begin
          id_pool[$urandom_range(IdPoolSize - 1)] = IdW'($urandom);
        end
        if ($urandom_range(3) == 0) begin
          id = IdW'($urandom);
        end else begin
          id = id_pool[$urandom_range(IdPoolSize - 1)];
        end
        roll = $urandom_range(99);
        if (roll < 4) begin
          key = '0;
        end else if (roll < 8) begin
          key = '1;
        end else if (roll < 40) begin
          key = KeyW'($urandom_range(15));
        end else begin
          key = KeyW'($urandom);
        end
        if ($urandom_range(99) < fill_pct) begin
          mode = $urandom_range(1) ? MODE_PRIO : MODE_TAIL;
        end else begin
          case ($urandom_range(2))
            0: mode = MODE_POP;
            1: mode = MODE_REMOVE;
            default: mode = MODE_QUERY;
          endcase
        end
        req = make_request(mode, id, key);
        send_request(req);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d queue transactions, %0d of them with unused modes, %0d results checked.",
             sent_count, spare_count, results);
    $display("Ran three sender gap and receiver stall profiles, with full and empty stores.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/epq_pkg.sv
rtl/epq_cell.sv
rtl/expiry_priority_queue_unit.sv
verif/epq_result_checker.sv
verif/tb.sv
